// File: src/ptw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared widths, codes and controller/datapath types for the page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

    localparam int unsigned TABLE_WORDS_DEF = 16384;
    localparam int unsigned LEVELS          = 4;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned PA_W     = 52;
    localparam int unsigned VA_W     = 48;
    localparam int unsigned WIDX_W   = 14;
    localparam int unsigned IDX_W    = 9;
    localparam int unsigned OFF_W    = 12;
    localparam int unsigned FRAME_W  = PA_W - OFF_W;
    localparam int unsigned WADDR_W  = FRAME_W + IDX_W;
    localparam int unsigned LEVEL_W  = $clog2(LEVELS);
    localparam int unsigned PRESENT_BIT = 0;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP  = LEVEL_W'(LEVELS - 1);
    localparam logic [LEVEL_W-1:0] LEVEL_LEAF = '0;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_XLATE = 1'b1;

    typedef struct packed {
        logic               start;
        logic               wr;
        logic               step;
        logic [LEVEL_W-1:0] lvl;
        logic               res_map;
        logic               set_pend;
        logic               load_out;
        logic               out_from_pend;
    } t_ptw_cmd;

    typedef struct packed {
        logic addr_ok;
        logic present;
    } t_ptw_sts;

endpackage

// File: src/ptw_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_ifs
// Request and response channels of the page table walker.
// ----------------------------------------------------------------------------
interface ptw_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [ptw_pkg::WIDX_W-1:0]  word_index;
    logic [ptw_pkg::WORD_W-1:0]  word_data;
    logic [ptw_pkg::VA_W-1:0]    vaddr;

    modport source (output valid, output func, output word_index, output word_data,
                    output vaddr, input ready);
    modport sink   (input valid, input func, input word_index, input word_data,
                    input vaddr, output ready);
endinterface

interface ptw_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [ptw_pkg::PA_W-1:0]  paddr;
    logic                      mapped;

    modport source (output valid, output paddr, output mapped, input ready);
    modport sink   (input valid, input paddr, input mapped, output ready);
endinterface

// File: src/ptw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ptw_ram #(
    parameter int unsigned WIDTH = ptw_pkg::WORD_W,
    parameter int unsigned DEPTH = ptw_pkg::TABLE_WORDS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/ptw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_dp
// Walker datapath: root register, table RAM, entry address, result registers.
// ----------------------------------------------------------------------------
module ptw_dp #(
    parameter int unsigned TABLE_WORDS = ptw_pkg::TABLE_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ptw_pkg::PA_W-1:0]    i_cfg_wdata,
    input  ptw_pkg::t_ptw_cmd           i_cmd,
    output ptw_pkg::t_ptw_sts           o_sts,
    input  logic [ptw_pkg::WIDX_W-1:0]  i_word_index,
    input  logic [ptw_pkg::WORD_W-1:0]  i_word_data,
    input  logic [ptw_pkg::VA_W-1:0]    i_vaddr,
    output logic [ptw_pkg::PA_W-1:0]    o_paddr,
    output logic                        o_mapped
);

    localparam int unsigned AW = $clog2(TABLE_WORDS);
    localparam logic [ptw_pkg::WADDR_W-1:0] LP_WORDS = ptw_pkg::WADDR_W'(TABLE_WORDS);

    logic [ptw_pkg::PA_W-1:0]    r_root;
    logic [ptw_pkg::VA_W-1:0]    r_va;
    logic [ptw_pkg::PA_W-1:0]    r_pend_pa;
    logic                        r_pend_map;
    logic [ptw_pkg::PA_W-1:0]    r_out_pa;
    logic                        r_out_map;

    logic [ptw_pkg::WORD_W-1:0]  rdata;
    logic [ptw_pkg::FRAME_W-1:0] base;
    logic [ptw_pkg::VA_W-1:0]    va_sel;
    logic [ptw_pkg::IDX_W-1:0]   idx;
    logic [ptw_pkg::WADDR_W-1:0] word;
    logic                        addr_ok;
    logic                        wr_ok;
    logic                        ram_en;
    logic [AW-1:0]               ram_addr;
    logic [ptw_pkg::PA_W-1:0]    res_pa;

    always_comb begin
        base   = i_cmd.step ? rdata[ptw_pkg::PA_W-1:ptw_pkg::OFF_W]
                            : r_root[ptw_pkg::PA_W-1:ptw_pkg::OFF_W];
        va_sel = i_cmd.start ? i_vaddr : r_va;
        idx    = va_sel[ptw_pkg::OFF_W + ptw_pkg::IDX_W * int'(i_cmd.lvl) +: ptw_pkg::IDX_W];
        word   = {base, idx};
        addr_ok = (word < LP_WORDS);
        wr_ok   = i_cmd.wr && (32'(i_word_index) < 32'(TABLE_WORDS));
        ram_en  = wr_ok || ((i_cmd.start || i_cmd.step) && addr_ok);
        ram_addr = i_cmd.wr ? AW'(i_word_index) : word[AW-1:0];
        res_pa  = i_cmd.res_map
                ? {rdata[ptw_pkg::PA_W-1:ptw_pkg::OFF_W], r_va[ptw_pkg::OFF_W-1:0]} : '0;
    end

    ptw_ram #(
        .WIDTH (ptw_pkg::WORD_W),
        .DEPTH (TABLE_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (wr_ok),
        .i_addr  (ram_addr),
        .i_wdata (i_word_data),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_cfg_we) begin
            r_root <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_va <= i_vaddr;
        end
        if (i_cmd.set_pend) begin
            r_pend_pa  <= res_pa;
            r_pend_map <= i_cmd.res_map;
        end
        if (i_cmd.load_out) begin
            r_out_pa  <= i_cmd.out_from_pend ? r_pend_pa  : res_pa;
            r_out_map <= i_cmd.out_from_pend ? r_pend_map : i_cmd.res_map;
        end
    end

    assign o_sts.addr_ok = addr_ok;
    assign o_sts.present = rdata[ptw_pkg::PRESENT_BIT];
    assign o_paddr       = r_out_pa;
    assign o_mapped      = r_out_map;

endmodule

// File: src/ptw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_ctrl
// Walker controller: accepts words, steps the levels, drives the output valid.
// ----------------------------------------------------------------------------
module ptw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_func,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    input  ptw_pkg::t_ptw_sts i_sts,
    output ptw_pkg::t_ptw_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state                        r_state, n_state;
    logic [ptw_pkg::LEVEL_W-1:0]   r_level, n_level;
    logic                          r_out_valid, n_out_valid;
    ptw_pkg::t_ptw_cmd             cmd;
    logic                          acc;
    logic                          out_free;
    logic                          fin;
    logic                          fin_map;

    assign acc      = i_req_valid && o_req_ready;
    assign out_free = !r_out_valid || i_rsp_ready;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_level     = r_level;
        n_out_valid = r_out_valid && !i_rsp_ready;
        fin         = 1'b0;
        fin_map     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_func == ptw_pkg::FUNC_WRITE) begin
                        cmd.wr = 1'b1;
                        fin    = 1'b1;
                    end else begin
                        cmd.start = 1'b1;
                        cmd.lvl   = ptw_pkg::LEVEL_TOP;
                        if (i_sts.addr_ok) begin
                            n_state = S_WALK;
                            n_level = ptw_pkg::LEVEL_TOP;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                end
            end
            S_WALK: begin
                if (!i_sts.present) begin
                    fin = 1'b1;
                end else if (r_level == ptw_pkg::LEVEL_LEAF) begin
                    fin     = 1'b1;
                    fin_map = 1'b1;
                end else begin
                    cmd.step = 1'b1;
                    cmd.lvl  = r_level - 1'b1;
                    if (i_sts.addr_ok) begin
                        n_level = r_level - 1'b1;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out      = 1'b1;
                    cmd.out_from_pend = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        cmd.res_map = fin_map;
        if (fin) begin
            if (out_free) begin
                cmd.load_out = 1'b1;
                n_state      = S_IDLE;
            end else begin
                cmd.set_pend = 1'b1;
                n_state      = S_DONE;
            end
        end
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = i_rst_n && (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_cmd       = cmd;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!r_out_valid || i_rsp_ready))
        else $error("output register overwritten while held");

    a_done_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> r_out_valid)
        else $error("pending result with empty output register");

    a_leaf_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_level == ptw_pkg::LEVEL_LEAF) |=> (r_state != S_WALK))
        else $error("walk continued past leaf level");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((cmd.start || cmd.step) && cmd.wr))
        else $error("table read and write in one cycle");

endmodule

// File: src/page_table_walker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_walker_core
// Four-level page table walker over a word-addressed table RAM.
//
//   channel   dir   payload                                   handshake
//   i_req     in    func, word_index, word_data, vaddr        valid/ready
//   o_rsp     out   paddr, mapped                             valid/ready
//   cfg       in    i_cfg_wdata (root table address)          i_cfg_we
//
// A table write is done when it is accepted; a translation does one dependent table
// RAM read per level and ends early when a level misses or an address is out of range.
// One request is handled at a time; i_req.ready is high only between walks.
// A result waits in the output register; a walk that ends while it is full
// parks in a pending register until o_rsp.ready frees it.
// Synchronous active-low reset clears the root register and all control.
// ----------------------------------------------------------------------------
module page_table_walker_core #(
    parameter int unsigned TABLE_WORDS = ptw_pkg::TABLE_WORDS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [ptw_pkg::PA_W-1:0] i_cfg_wdata,
    ptw_req_if.sink                  i_req,
    ptw_rsp_if.source                o_rsp
);

    ptw_pkg::t_ptw_cmd cmd;
    ptw_pkg::t_ptw_sts sts;
    logic              req_ready;
    logic              rsp_valid;

    ptw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_func      (i_req.func),
        .o_req_ready (req_ready),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ptw_dp #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_word_index (i_req.word_index),
        .i_word_data  (i_req.word_data),
        .i_vaddr      (i_req.vaddr),
        .o_paddr      (o_rsp.paddr),
        .o_mapped     (o_rsp.mapped)
    );

    assign i_req.ready = req_ready;
    assign o_rsp.valid = rsp_valid;

endmodule
